// ===== design/mmsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mmsb_pkg
// Shared types and codes for the matrix multiply block: items, config,
// load bus, cell token and cell result.
// ----------------------------------------------------------------------------
package mmsb_pkg;

  localparam logic [1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  localparam logic [1:0] CFG_ROWS_A = 2'd0;
  localparam logic [1:0] CFG_COLS_A = 2'd1;
  localparam logic [1:0] CFG_ROWS_B = 2'd2;
  localparam logic [1:0] CFG_COLS_B = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] elem_value;
    logic [2:0]         elem_row;
    logic [2:0]         elem_col;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic               last;
    logic               dim_error;
  } out_item_t;

  typedef struct packed {
    logic [3:0] rows_a;
    logic [3:0] cols_a;
    logic [3:0] rows_b;
    logic [3:0] cols_b;
  } cfg_t;

  typedef struct packed {
    logic               we_a;
    logic               we_b;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] val;
  } ld_t;

  typedef struct packed {
    logic               vld;
    logic               sel_a;
    logic               first;
    logic               lastk;
    logic               rowlast;
    logic [2:0]         k;
    logic [2:0]         row;
    logic signed [31:0] val;
  } tok_t;

  typedef struct packed {
    logic               vld;
    logic               last;
    logic [2:0]         row;
    logic signed [31:0] val;
  } cres_t;

endpackage

// ===== design/mmsb_cell.sv =====
// ----------------------------------------------------------------------------
// mmsb_cell
// One column cell: holds column COL of A and B, multiplies the passing
// token by its local element, accumulates a dot product and saturates it.
// ----------------------------------------------------------------------------
module mmsb_cell #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16,
  parameter int COL       = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmsb_pkg::ld_t                 ld,
  input  logic [$clog2(MAX_DIM+1)-1:0]  nc,
  input  mmsb_pkg::tok_t                tok_in,
  output mmsb_pkg::tok_t                tok_out,
  output mmsb_pkg::cres_t               res
);
  import mmsb_pkg::*;

  localparam int IW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int AW = 64 + IW + 1;

  logic signed [31:0]   amem [MAX_DIM];
  logic signed [31:0]   bmem [MAX_DIM];
  tok_t                 tok_r;
  logic signed [31:0]   opnd_r;
  logic signed [63:0]   prod_r;
  logic                 p_vld_r, p_first_r, p_lastk_r, p_rowlast_r;
  logic [2:0]           p_row_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_nxt;
  logic                 d_vld_r, d_rowlast_r;
  logic [2:0]           d_row_r;
  logic signed [AW-1:0] shf;
  logic signed [31:0]   sat;
  logic                 fits;
  cres_t                res_r;

  wire ld_here = (ld.col == 3'(COL));

  always_ff @(posedge clk) begin
    if (ld.we_a && ld_here) begin
      amem[ld.row[IW-1:0]] <= ld.val;
    end
    if (ld.we_b && ld_here) begin
      bmem[ld.row[IW-1:0]] <= ld.val;
    end
    opnd_r <= tok_in.sel_a ? amem[tok_in.k[IW-1:0]] : bmem[tok_in.k[IW-1:0]];
  end

  assign acc_nxt = (p_first_r ? '0 : acc_r) + AW'(prod_r);
  assign shf     = acc_r >>> FRAC_BITS;
  assign fits    = (&shf[AW-1:31]) || !(|shf[AW-1:31]);
  assign sat     = fits ? shf[31:0] : (shf[AW-1] ? 32'sh80000000 : 32'sh7FFFFFFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= '0;
      p_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      res_r.vld <= 1'b0;
    end else begin
      tok_r       <= tok_in;
      p_vld_r     <= tok_r.vld;
      p_first_r   <= tok_r.first;
      p_lastk_r   <= tok_r.lastk;
      p_rowlast_r <= tok_r.rowlast;
      p_row_r     <= tok_r.row;
      prod_r      <= $signed(tok_r.val) * $signed(opnd_r);
      if (p_vld_r) begin
        acc_r <= acc_nxt;
      end
      d_vld_r     <= p_vld_r && p_lastk_r;
      d_rowlast_r <= p_rowlast_r;
      d_row_r     <= p_row_r;
      res_r.vld   <= d_vld_r && (DW'(COL) < nc);
      res_r.last  <= d_rowlast_r && (DW'(COL) == nc - DW'(1));
      res_r.row   <= d_row_r;
      res_r.val   <= sat;
    end
  end

  assign tok_out = tok_r;
  assign res     = res_r;

endmodule

// ===== design/mmsb_seq.sv =====
// ----------------------------------------------------------------------------
// mmsb_seq
// Run sequencer: picks the product mode, holds the A store, and feeds one
// token per inner-product step into the head of the cell chain.
// ----------------------------------------------------------------------------
module mmsb_seq #(
  parameter int MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_cmp,
  input  mmsb_pkg::ld_t                 ld,
  input  mmsb_pkg::cfg_t                cfg,
  input  logic                          done,
  output logic                          busy,
  output logic                          err_vld,
  output mmsb_pkg::tok_t                tok,
  output logic [$clog2(MAX_DIM+1)-1:0]  nc
);
  import mmsb_pkg::*;

  localparam int IW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_ERR} state_t;
  typedef enum logic [1:0] {MD_NORM, MD_ASC, MD_BSC} mode_t;

  function automatic logic [DW-1:0] eff_dim(input logic [3:0] v);
    if (v == 4'd0) begin
      return DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(v);
    end
  endfunction

  logic signed [31:0] amem [MAX_DIM*MAX_DIM];
  logic signed [31:0] a_rd_r;
  logic signed [31:0] b00_r;
  state_t             state_r;
  mode_t              mode_r;
  logic [DW-1:0]      nr_r, nc_r, inner_r, span_r;
  logic [IW-1:0]      i_r, s_r;
  logic               err_r;
  tok_t               t1_r;
  tok_t               t0;
  logic [AW-1:0]      rd_addr;
  logic [DW-1:0]      ra, ca, rb, cb;
  logic               a_one, b_one;

  assign ra    = eff_dim(cfg.rows_a);
  assign ca    = eff_dim(cfg.cols_a);
  assign rb    = eff_dim(cfg.rows_b);
  assign cb    = eff_dim(cfg.cols_b);
  assign a_one = (ra == DW'(1)) && (ca == DW'(1));
  assign b_one = (rb == DW'(1)) && (cb == DW'(1));

  assign rd_addr = (mode_r == MD_NORM) ? AW'(int'(i_r) * MAX_DIM + int'(s_r)) : '0;

  always_comb begin
    t0         = '0;
    t0.vld     = (state_r == ST_RUN) && (DW'(s_r) < inner_r);
    t0.sel_a   = (mode_r == MD_BSC);
    t0.first   = (s_r == '0);
    t0.lastk   = (DW'(s_r) == inner_r - DW'(1));
    t0.rowlast = (DW'(i_r) == nr_r - DW'(1));
    t0.k       = (mode_r == MD_NORM) ? 3'(s_r) : 3'(i_r);
    t0.row     = 3'(i_r);
  end

  always_ff @(posedge clk) begin
    if (ld.we_a) begin
      amem[AW'(int'(ld.row) * MAX_DIM + int'(ld.col))] <= ld.val;
    end
    if (ld.we_b && ld.row == 3'd0 && ld.col == 3'd0) begin
      b00_r <= ld.val;
    end
    a_rd_r <= amem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MD_NORM;
      err_r   <= 1'b0;
      t1_r    <= '0;
      i_r     <= '0;
      s_r     <= '0;
      nr_r    <= DW'(1);
      nc_r    <= DW'(1);
      inner_r <= DW'(1);
      span_r  <= DW'(1);
    end else begin
      t1_r <= t0;
      case (state_r)
        ST_IDLE: begin
          i_r <= '0;
          s_r <= '0;
          if (start_cmp) begin
            if (a_one) begin
              mode_r <= MD_ASC; nr_r <= rb; nc_r <= cb; inner_r <= DW'(1);
              span_r <= cb;
              state_r <= ST_RUN;
            end else if (b_one) begin
              mode_r <= MD_BSC; nr_r <= ra; nc_r <= ca; inner_r <= DW'(1);
              span_r <= ca;
              state_r <= ST_RUN;
            end else if (ca != rb) begin
              err_r   <= 1'b1;
              state_r <= ST_ERR;
            end else begin
              mode_r <= MD_NORM; nr_r <= ra; nc_r <= cb; inner_r <= ca;
              span_r <= (ca > cb) ? ca : cb;
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (DW'(s_r) == span_r - DW'(1)) begin
            s_r <= '0;
            if (DW'(i_r) == nr_r - DW'(1)) begin
              state_r <= ST_DRAIN;
            end else begin
              i_r <= i_r + IW'(1);
            end
          end else begin
            s_r <= s_r + IW'(1);
          end
        end
        ST_DRAIN: begin
          if (done) begin
            state_r <= ST_IDLE;
          end
        end
        ST_ERR: begin
          err_r   <= 1'b0;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    tok     = t1_r;
    tok.val = t1_r.sel_a ? b00_r : a_rd_r;
  end

  assign busy    = (state_r != ST_IDLE);
  assign err_vld = err_r;
  assign nc      = nc_r;

endmodule

// ===== design/matrix_multiply_scalar_broadcast.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_scalar_broadcast
// Fixed-point matrix product over a chain of column cells.
// ----------------------------------------------------------------------------
// Loads are taken whenever busy is low. A compute item streams its
// results one per cycle, row-major, with no back-pressure: the receiver
// must take each result in its cycle. The sequencer feeds each result row
// into the column-cell chain as one token per inner index, padded up to
// the number of result columns when that is larger. A dimension mismatch
// gives a single error result in the cycle right after the compute item is
// taken. No clearing pass after reset.
module matrix_multiply_scalar_broadcast #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  mmsb_pkg::in_item_t    in_item,
  output logic                  out_strobe,
  output mmsb_pkg::out_item_t   out_item,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [3:0]            cfg_wdata
);
  import mmsb_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);

  cfg_t          cfg_r;
  ld_t           ld;
  logic          start_cmp;
  logic          err_vld;
  logic          done;
  logic [DW-1:0] nc;
  tok_t          chain [MAX_DIM+1];
  cres_t         cres  [MAX_DIM];
  logic [MAX_DIM-1:0] cvld;
  out_item_t     o;
  logic          accept, in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{4'd1, 4'd1, 4'd1, 4'd1};
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROWS_A: cfg_r.rows_a <= cfg_wdata;
        CFG_COLS_A: cfg_r.cols_a <= cfg_wdata;
        CFG_ROWS_B: cfg_r.rows_b <= cfg_wdata;
        CFG_COLS_B: cfg_r.cols_b <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign accept    = start && !busy;
  assign in_range  = (int'(in_item.elem_row) < MAX_DIM) && (int'(in_item.elem_col) < MAX_DIM);
  assign start_cmp = accept && (in_item.action == ACT_COMPUTE);

  always_comb begin
    ld.we_a = accept && in_range && (in_item.action == ACT_LOAD_A);
    ld.we_b = accept && in_range && (in_item.action == ACT_LOAD_B);
    ld.row  = in_item.elem_row;
    ld.col  = in_item.elem_col;
    ld.val  = in_item.elem_value;
  end

  mmsb_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_cmp (start_cmp),
    .ld        (ld),
    .cfg       (cfg_r),
    .done      (done),
    .busy      (busy),
    .err_vld   (err_vld),
    .tok       (chain[0]),
    .nc        (nc)
  );

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mmsb_cell #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .COL(j)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ld      (ld),
      .nc      (nc),
      .tok_in  (chain[j]),
      .tok_out (chain[j+1]),
      .res     (cres[j])
    );
    assign cvld[j] = cres[j].vld;
  end

  always_comb begin
    o = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (cres[j].vld) begin
        o.out_value = o.out_value | cres[j].val;
        o.out_row   = o.out_row | cres[j].row;
        o.out_col   = o.out_col | 3'(j);
        o.last      = o.last | cres[j].last;
      end
    end
    if (err_vld) begin
      o.last      = 1'b1;
      o.dim_error = 1'b1;
    end
  end

  assign out_item   = o;
  assign out_strobe = err_vld || (|cvld);
  assign done       = out_strobe && o.last;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({err_vld, cvld}))
    else $error("more than one result in a cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result while idle");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    err_vld |=> !err_vld)
    else $error("error result repeated");

endmodule

// ===== dv/mmsb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsb_checker
// Watches the item, result and config channels of the matrix multiply block,
// predicts every product element from its own copy of both stores and the
// shape registers, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module mmsb_checker #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  mmsb_pkg::in_item_t  in_item,
  input  logic                out_strobe,
  input  mmsb_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [3:0]          cfg_wdata,
  output int                  fails,
  output int                  pending
);
  import mmsb_pkg::*;

  logic signed [31:0] a_mat [MAX_DIM*MAX_DIM];
  logic signed [31:0] b_mat [MAX_DIM*MAX_DIM];
  cfg_t               shape;
  out_item_t          product_q [$];
  int                 mismatches;

  function automatic int eff_dim(logic [3:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  function automatic logic signed [31:0] dot_round(logic signed [127:0] acc);
    logic signed [127:0] sh;
    sh = acc >>> FRAC_BITS;
    if (sh > 128'sd2147483647) return 32'sh7fffffff;
    if (sh < -128'sd2147483648) return 32'sh80000000;
    return sh[31:0];
  endfunction

  function automatic logic signed [127:0] mul_wide(logic signed [31:0] x,
                                                   logic signed [31:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return {{64{p[63]}}, p};
  endfunction

  task automatic predict_products(in_item_t it);
    int ra, ca, rb, cb, nr, nc;
    logic signed [127:0] acc;
    out_item_t e;
    ra = eff_dim(shape.rows_a);
    ca = eff_dim(shape.cols_a);
    rb = eff_dim(shape.rows_b);
    cb = eff_dim(shape.cols_b);
    if (ra * ca == 1) begin
      nr = rb; nc = cb;
    end else if (rb * cb == 1) begin
      nr = ra; nc = ca;
    end else if (ca != rb) begin
      e = '0;
      e.last = 1'b1;
      e.dim_error = 1'b1;
      product_q.push_back(e);
      return;
    end else begin
      nr = ra; nc = cb;
    end
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = '0;
        if (ra * ca == 1)
          acc = mul_wide(a_mat[0], b_mat[i*MAX_DIM+j]);
        else if (rb * cb == 1)
          acc = mul_wide(b_mat[0], a_mat[i*MAX_DIM+j]);
        else
          for (int k = 0; k < ca; k++)
            acc = acc + mul_wide(a_mat[i*MAX_DIM+k], b_mat[k*MAX_DIM+j]);
        e.out_value = dot_round(acc);
        e.out_row   = 3'(i);
        e.out_col   = 3'(j);
        e.last      = (i + 1 == nr) && (j + 1 == nc);
        e.dim_error = 1'b0;
        product_q.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      for (int n = 0; n < MAX_DIM*MAX_DIM; n++) begin
        a_mat[n] = '0;
        b_mat[n] = '0;
      end
      shape = {4'd1, 4'd1, 4'd1, 4'd1};
      product_q.delete();
      fails <= 0;
      mismatches = 0;
      pending <= 0;
    end else begin
      if (out_strobe) begin
        if (product_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %h row %0d col %0d last %b err %b",
                     out_item.out_value, out_item.out_row, out_item.out_col,
                     out_item.last, out_item.dim_error);
        end else begin
          e = product_q.pop_front();
          if (e !== out_item) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp value %h row %0d col %0d last %b err %b,",
                        " got value %h row %0d col %0d last %b err %b"},
                       e.out_value, e.out_row, e.out_col, e.last, e.dim_error,
                       out_item.out_value, out_item.out_row, out_item.out_col,
                       out_item.last, out_item.dim_error);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ROWS_A: shape.rows_a = cfg_wdata;
          CFG_COLS_A: shape.cols_a = cfg_wdata;
          CFG_ROWS_B: shape.rows_b = cfg_wdata;
          CFG_COLS_B: shape.cols_b = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_item.action)
          ACT_LOAD_A:  a_mat[in_item.elem_row*MAX_DIM+in_item.elem_col] = in_item.elem_value;
          ACT_LOAD_B:  b_mat[in_item.elem_row*MAX_DIM+in_item.elem_col] = in_item.elem_value;
          ACT_COMPUTE: predict_products(in_item);
          default: ;
        endcase
      end
      fails   <= mismatches;
      pending <= product_q.size();
    end
  end

endmodule

// ===== dv/tb_matrix_multiply_scalar_broadcast.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_scalar_broadcast
// Drives load and compute items over many matrix shapes, scalar, mismatched
// and out-of-range register values included, with random sender gaps; the
// checker predicts and compares every product element.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_scalar_broadcast;
  import mmsb_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int MAX_DIM = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_strobe;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_ROWS_A;
  logic [3:0] cfg_wdata = 4'd1;
  int         fails;
  int         pending;

  bit a_done [MAX_DIM*MAX_DIM];
  bit b_done [MAX_DIM*MAX_DIM];
  int sent;
  int idle_pct;

  always #10 clk = ~clk;

  matrix_multiply_scalar_broadcast uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  mmsb_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int eff_dim(logic [3:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  function automatic logic [31:0] pick_val(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
      default: return 32'h00010000 + $urandom_range(0, 511) - 256;
    endcase
  endfunction

  task automatic send(logic [1:0] act, logic [31:0] v, int r, int c);
    int gap;
    in_item.action     <= act;
    in_item.elem_value <= v;
    in_item.elem_row   <= 3'(r);
    in_item.elem_col   <= 3'(c);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (act == ACT_LOAD_A) a_done[r*MAX_DIM+c] = 1'b1;
    if (act == ACT_LOAD_B) b_done[r*MAX_DIM+c] = 1'b1;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_job(logic [3:0] ra_w, logic [3:0] ca_w, logic [3:0] rb_w,
                         logic [3:0] cb_w, int mode, int extra);
    int ra, ca, rb, cb;
    logic [3:0] w [4];
    drain();
    w = '{ra_w, ca_w, rb_w, cb_w};
    for (int n = 0; n < 4; n++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= 2'(n);
      cfg_wdata <= w[n];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ra = eff_dim(ra_w); ca = eff_dim(ca_w);
    rb = eff_dim(rb_w); cb = eff_dim(cb_w);
    for (int n = 0; n < extra; n++) begin
      case ($urandom_range(0, 9))
        0: send(ACT_UNUSED, $urandom, $urandom_range(0, 7), $urandom_range(0, 7));
        1, 2: send(ACT_LOAD_A, pick_val(mode), $urandom_range(0, 7), $urandom_range(0, 7));
        3, 4: send(ACT_LOAD_B, pick_val(mode), $urandom_range(0, 7), $urandom_range(0, 7));
        5, 6, 7: send(ACT_LOAD_A, pick_val(mode), $urandom_range(0, ra-1),
                      $urandom_range(0, ca-1));
        default: send(ACT_LOAD_B, pick_val(mode), $urandom_range(0, rb-1),
                      $urandom_range(0, cb-1));
      endcase
    end
    for (int i = 0; i < ra; i++)
      for (int j = 0; j < ca; j++)
        if (!a_done[i*MAX_DIM+j]) send(ACT_LOAD_A, pick_val(mode), i, j);
    for (int i = 0; i < rb; i++)
      for (int j = 0; j < cb; j++)
        if (!b_done[i*MAX_DIM+j]) send(ACT_LOAD_B, pick_val(mode), i, j);
    send(ACT_COMPUTE, $urandom, $urandom_range(0, 7), $urandom_range(0, 7));
  endtask

  function automatic logic [3:0] pick_dim;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 4'($urandom_range(1, 3));
      6: return 4'd8;
      7: return ($urandom_range(0, 1)) ? 4'd0 : 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(4, 7));
    endcase
  endfunction

  initial begin
    logic [3:0] ra, ca, rb, cb;
    sent = 0;
    idle_pct = 11;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(ACT_LOAD_A, 32'h7fffffff, 0, 0);
    send(ACT_LOAD_B, 32'h7fffffff, 0, 0);
    send(ACT_COMPUTE, 32'h0, 0, 0);
    send(ACT_LOAD_A, 32'h80000000, 0, 0);
    send(ACT_COMPUTE, 32'hffffffff, 7, 7);
    send(ACT_UNUSED, 32'hffffffff, 7, 7);
    send(ACT_LOAD_A, 32'hffffffff, 7, 7);
    send(ACT_LOAD_B, 32'h80000000, 7, 7);
    run_job(4'd1, 4'd1, 4'd2, 4'd3, 3, 0);
    run_job(4'd2, 4'd2, 4'd1, 4'd1, 2, 0);
    run_job(4'd2, 4'd3, 4'd2, 4'd2, 0, 0);
    run_job(4'd8, 4'd8, 4'd8, 4'd8, 2, 0);
    run_job(4'd0, 4'd15, 4'd15, 4'd0, 1, 0);

    while (sent < 420) begin
      if (sent > 290) idle_pct = 0;
      else if (sent > 160) idle_pct = 56;
      ra = pick_dim(); ca = pick_dim(); rb = pick_dim(); cb = pick_dim();
      case ($urandom_range(0, 19))
        0, 1, 2: begin ra = 4'd1; ca = 4'd1; end
        3, 4, 5: begin rb = 4'd1; cb = 4'd1; end
        6, 7, 8, 9, 10, 11, 12, 13: rb = ca;
        default: ;
      endcase
      run_job(ra, ca, rb, cb, $urandom_range(0, 3), $urandom_range(0, 10));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mmsb_pkg.sv
design/mmsb_cell.sv
design/mmsb_seq.sv
design/matrix_multiply_scalar_broadcast.sv
dv/mmsb_checker.sv
dv/tb_matrix_multiply_scalar_broadcast.sv
